### rtl/rwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_pkg
// shared codes and constants of the rgb window convolution
// ----------------------------------------------------------------------------
package rwc_pkg;

    localparam int NUM_TAPS  = 9;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = 8;
    localparam int FRAC_BITS = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;
    localparam int OUT_W     = 16;

    localparam logic [OUT_W-1:0] CLAMP_MAX = 16'd255;
    localparam logic [OUT_W-1:0] CLAMP_MIN = 16'd0;
    localparam logic [OUT_W-1:0] SAT_MAX   = 16'h7fff;
    localparam logic [OUT_W-1:0] SAT_MIN   = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP    = 3'd0,
        CFG_COEF_MIDDLE = 3'd1,
        CFG_COEF_BOTTOM = 3'd2,
        CFG_NORMALIZE   = 3'd3,
        CFG_CLAMP       = 3'd4
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_chan;

endpackage

### rtl/rgb_window_convolution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_window_convolution
// 3x3 convolution of a window of packed rgb pixels
// ----------------------------------------------------------------------------
// Takes one 3x3 window word per clock and returns one filtered rgb word per
// clock while the output is not stalled. The pipe has one product stage,
// two adder stages, one rounding prep stage, one stage per quotient bit of
// the pipelined divider and the output register. Three identical lanes
// (red, green, blue) run side by side and the merge stage applies sign and
// limit. The whole pipe advances together; it holds only while a finished
// word waits under output stall. Configuration is taken at any time (ready
// is always high) but must only be written while the pipe is empty; the
// coefficient sum is registered behind the coefficient registers.
// ----------------------------------------------------------------------------
module rgb_window_convolution #(
    parameter int KERNEL_SIZE = 3,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rwc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rwc_pkg::CFG_W-1:0]          i_cfg_data,
    // window input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [23:0]                        i_pix_r0c0,
    input  logic [23:0]                        i_pix_r0c1,
    input  logic [23:0]                        i_pix_r0c2,
    input  logic [23:0]                        i_pix_r1c0,
    input  logic [23:0]                        i_pix_r1c1,
    input  logic [23:0]                        i_pix_r1c2,
    input  logic [23:0]                        i_pix_r2c0,
    input  logic [23:0]                        i_pix_r2c1,
    input  logic [23:0]                        i_pix_r2c2,
    // pixel output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [15:0]                 o_red_out,
    output logic signed [15:0]                 o_green_out,
    output logic signed [15:0]                 o_blue_out,
    output logic                               o_zero_sum_flag
);

    localparam int ACC_W   = COEF_WIDTH + 12;
    localparam int NW      = ACC_W + 1;
    localparam int AD_W    = (COEF_WIDTH + 3 > 13) ? COEF_WIDTH + 3 : 13;
    localparam int CS_W    = COEF_WIDTH + 4;
    localparam int LAT     = 5 + NW;
    localparam int LO      = (3 - KERNEL_SIZE) / 2;
    localparam logic [AD_W-1:0] ONE_Q = AD_W'(1 << rwc_pkg::FRAC_BITS);

    // configuration registers
    logic [rwc_pkg::CFG_W-1:0] r_coef_top;
    logic [rwc_pkg::CFG_W-1:0] r_coef_mid;
    logic [rwc_pkg::CFG_W-1:0] r_coef_bot;
    logic                      r_norm;
    logic                      r_clamp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= 48'h0000_1000_0000;
            r_coef_bot <= '0;
            r_norm     <= 1'b0;
            r_clamp    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rwc_pkg::CFG_COEF_TOP:    r_coef_top <= i_cfg_data;
                rwc_pkg::CFG_COEF_MIDDLE: r_coef_mid <= i_cfg_data;
                rwc_pkg::CFG_COEF_BOTTOM: r_coef_bot <= i_cfg_data;
                rwc_pkg::CFG_NORMALIZE:   r_norm     <= i_cfg_data[0];
                rwc_pkg::CFG_CLAMP:       r_clamp    <= i_cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // coefficients, outside the centred kernel square forced to zero
    logic signed [COEF_WIDTH-1:0] w_coef [rwc_pkg::NUM_TAPS];
    logic [rwc_pkg::CFG_W-1:0]    w_row  [3];

    assign w_row[0] = r_coef_top;
    assign w_row[1] = r_coef_mid;
    assign w_row[2] = r_coef_bot;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r >= LO && r < LO + KERNEL_SIZE && c >= LO && c < LO + KERNEL_SIZE) begin
                    w_coef[3*r+c] = $signed(w_row[r][c*COEF_WIDTH +: COEF_WIDTH]);
                end else begin
                    w_coef[3*r+c] = '0;
                end
            end
        end
    end

    // divisor: magnitude of the coefficient sum in normalise mode if nonzero, else 1.0 in q4.12
    logic signed [CS_W-1:0] w_csum;
    logic [AD_W-1:0]        r_ad;
    logic                   r_den_neg;
    logic                   r_flag;

    always_comb begin
        w_csum = '0;
        for (int t = 0; t < rwc_pkg::NUM_TAPS; t++) begin
            w_csum = w_csum + CS_W'(w_coef[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad      <= ONE_Q;
            r_den_neg <= 1'b0;
            r_flag    <= 1'b0;
        end else if (r_norm && w_csum != '0) begin
            r_ad      <= w_csum[CS_W-1] ? AD_W'(-w_csum) : AD_W'(w_csum);
            r_den_neg <= w_csum[CS_W-1];
            r_flag    <= 1'b0;
        end else begin
            r_ad      <= ONE_Q;
            r_den_neg <= 1'b0;
            r_flag    <= r_norm;
        end
    end

    // pipe control: all stages move together unless the output word is held
    logic           w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv       = !r_vld[LAT-1] || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // split the window into colour lanes
    logic [23:0]     w_pix [rwc_pkg::NUM_TAPS];
    rwc_pkg::t_chan  w_ch  [rwc_pkg::NUM_CH][rwc_pkg::NUM_TAPS];
    logic [NW-1:0]   w_q   [rwc_pkg::NUM_CH];
    logic            w_neg [rwc_pkg::NUM_CH];
    logic signed [15:0] w_out [rwc_pkg::NUM_CH];

    assign w_pix[0] = i_pix_r0c0;
    assign w_pix[1] = i_pix_r0c1;
    assign w_pix[2] = i_pix_r0c2;
    assign w_pix[3] = i_pix_r1c0;
    assign w_pix[4] = i_pix_r1c1;
    assign w_pix[5] = i_pix_r1c2;
    assign w_pix[6] = i_pix_r2c0;
    assign w_pix[7] = i_pix_r2c1;
    assign w_pix[8] = i_pix_r2c2;

    always_comb begin
        for (int t = 0; t < rwc_pkg::NUM_TAPS; t++) begin
            w_ch[0][t] = w_pix[t][23:16];
            w_ch[1][t] = w_pix[t][15:8];
            w_ch[2][t] = w_pix[t][7:0];
        end
    end

    for (genvar l = 0; l < rwc_pkg::NUM_CH; l++) begin : g_lane
        rwc_lane #(
            .COEF_WIDTH (COEF_WIDTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_adv     (w_adv),
            .i_pix     (w_ch[l]),
            .i_coef    (w_coef),
            .i_ad      (r_ad),
            .i_den_neg (r_den_neg),
            .o_q       (w_q[l]),
            .o_neg     (w_neg[l])
        );
    end

    rwc_merge #(
        .QW (NW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_q     (w_q),
        .i_neg   (w_neg),
        .i_clamp (r_clamp),
        .i_flag  (r_flag),
        .o_ch    (w_out),
        .o_flag  (o_zero_sum_flag)
    );

    assign o_red_out   = w_out[0];
    assign o_green_out = w_out[1];
    assign o_blue_out  = w_out[2];

    // the flag can only come out of normalise mode
    a_flag_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_sum_flag |-> r_norm)
        else $error("zero sum flag outside normalise mode");

    // clamp mode keeps every channel in 0..255
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_clamp |->
            o_red_out >= 0 && o_red_out <= 255 &&
            o_green_out >= 0 && o_green_out <= 255 &&
            o_blue_out >= 0 && o_blue_out <= 255)
        else $error("clamped channel out of range");

    // input is held back only by a waiting output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held output word");

endmodule

### rtl/rwc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_lane
// one colour lane: nine products, adder tree, rounded pipelined division
// ----------------------------------------------------------------------------
module rwc_lane #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_adv,
    input  rwc_pkg::t_chan                    i_pix  [rwc_pkg::NUM_TAPS],
    input  logic signed [COEF_WIDTH-1:0]      i_coef [rwc_pkg::NUM_TAPS],
    input  logic [((COEF_WIDTH+3 > 13) ? COEF_WIDTH+3 : 13)-1:0] i_ad,
    input  logic                              i_den_neg,
    output logic [COEF_WIDTH+12:0]            o_q,
    output logic                              o_neg
);

    localparam int PW    = COEF_WIDTH + 9;
    localparam int ACC_W = COEF_WIDTH + 12;
    localparam int AD_W  = (COEF_WIDTH + 3 > 13) ? COEF_WIDTH + 3 : 13;
    localparam int DW    = AD_W + 1;
    localparam int NW    = ACC_W + 1;

    logic signed [PW-1:0]    r_prod [rwc_pkg::NUM_TAPS];
    logic signed [ACC_W-1:0] r_row  [3];
    logic signed [ACC_W-1:0] r_acc;
    logic [NW-1:0]           r_num;
    logic                    r_neg0;
    logic [NW-1:0]           r_n [NW];
    logic [DW-1:0]           r_r [NW];
    logic [NW-1:0]           r_qv [NW];
    logic                    r_ng [NW];
    logic [DW-1:0]           w_den2;

    assign w_den2 = {i_ad, 1'b0};

    // products, then row sums, then the total
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int t = 0; t < rwc_pkg::NUM_TAPS; t++) begin
                r_prod[t] <= PW'($signed({1'b0, i_pix[t]}) * i_coef[t]);
            end
            for (int r = 0; r < 3; r++) begin
                r_row[r] <= ACC_W'(r_prod[3*r]) + ACC_W'(r_prod[3*r+1])
                          + ACC_W'(r_prod[3*r+2]);
            end
            r_acc <= r_row[0] + r_row[1] + r_row[2];
        end
    end

    // 2|n| + |d| over 2|d| gives round half away from zero
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num  <= {(r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc)), 1'b0}
                    + NW'(i_ad);
            r_neg0 <= r_acc[ACC_W-1] ^ i_den_neg;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [NW-1:0] w_nin;
        logic [DW-1:0] w_rin;
        logic [NW-1:0] w_qin;
        logic          w_gin;
        logic [DW:0]   w_trial;
        logic          w_ge;
        if (k == 0) begin : g_first
            assign w_nin = r_num;
            assign w_rin = '0;
            assign w_qin = '0;
            assign w_gin = r_neg0;
        end else begin : g_next
            assign w_nin = r_n[k-1];
            assign w_rin = r_r[k-1];
            assign w_qin = r_qv[k-1];
            assign w_gin = r_ng[k-1];
        end
        assign w_trial = {w_rin, w_nin[NW-1]};
        assign w_ge    = w_trial >= {1'b0, w_den2};
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_n[k]  <= {w_nin[NW-2:0], 1'b0};
                r_r[k]  <= w_ge ? DW'(w_trial - {1'b0, w_den2}) : w_trial[DW-1:0];
                r_qv[k] <= {w_qin[NW-2:0], w_ge};
                r_ng[k] <= w_gin;
            end
        end
    end

    assign o_q   = r_qv[NW-1];
    assign o_neg = r_ng[NW-1];

endmodule

### rtl/rwc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_merge
// output stage: applies sign and limit to each lane and registers the word
// ----------------------------------------------------------------------------
module rwc_merge #(
    parameter int QW = 29
) (
    input  logic                                i_clk,
    input  logic                                i_adv,
    input  logic [QW-1:0]                       i_q   [rwc_pkg::NUM_CH],
    input  logic                                i_neg [rwc_pkg::NUM_CH],
    input  logic                                i_clamp,
    input  logic                                i_flag,
    output logic signed [rwc_pkg::OUT_W-1:0]    o_ch  [rwc_pkg::NUM_CH],
    output logic                                o_flag
);

    logic [rwc_pkg::OUT_W-1:0] w_lim [rwc_pkg::NUM_CH];

    always_comb begin
        for (int c = 0; c < rwc_pkg::NUM_CH; c++) begin
            if (i_clamp) begin
                if (i_neg[c] || i_q[c] == '0) begin
                    w_lim[c] = rwc_pkg::CLAMP_MIN;
                end else if (i_q[c] > QW'(rwc_pkg::CLAMP_MAX)) begin
                    w_lim[c] = rwc_pkg::CLAMP_MAX;
                end else begin
                    w_lim[c] = i_q[c][rwc_pkg::OUT_W-1:0];
                end
            end else if (i_neg[c]) begin
                if (i_q[c] > QW'({1'b0, rwc_pkg::SAT_MIN})) begin
                    w_lim[c] = rwc_pkg::SAT_MIN;
                end else begin
                    w_lim[c] = rwc_pkg::OUT_W'(-i_q[c]);
                end
            end else if (i_q[c] > QW'(rwc_pkg::SAT_MAX)) begin
                w_lim[c] = rwc_pkg::SAT_MAX;
            end else begin
                w_lim[c] = i_q[c][rwc_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < rwc_pkg::NUM_CH; c++) begin
                o_ch[c] <= $signed(w_lim[c]);
            end
            o_flag <= i_flag;
        end
    end

endmodule
